FILE: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);

    localparam logic [ADDR_W-1:0] LAST_CELL      = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(CELL_COUNT - SCREEN_WIDTH);
    // scroll copy: reads are issued one cell ahead while the write pointer is below this
    localparam logic [ADDR_W-1:0] COPY_READ_END  = ADDR_W'(CELL_COUNT - SCREEN_WIDTH - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP       = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] READ_AHEAD     = ADDR_W'(SCREEN_WIDTH + 1);
    localparam logic [COL_W-1:0]  LAST_COL       = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW       = ROW_W'(SCREEN_HEIGHT - 1);

    localparam logic [15:0] BLANK_CELL   = 16'h0700;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } t_req;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic        scrolled;
        logic [15:0] read_data;
    } t_res;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PUT,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        cell_word;
        logic [ADDR_W-1:0]  idx;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/tcw_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes requests into commands and holds them in a two-entry queue.
module tcw_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tcw_pkg::t_req i_req,
    output logic               o_full,
    output logic               o_cmd_valid,
    output tcw_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_pop
);
    import tcw_pkg::*;

    t_cmd       cmd_in;
    t_cmd       r_q [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;

    always_comb begin
        cmd_in.cell_word = {i_req.color, i_req.char_code};
        cmd_in.idx       = ADDR_W'(i_req.cell_index);
        case (i_req.req_type)
            REQ_PUT: begin
                cmd_in.kind = (i_req.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
            end
            REQ_CLEAR: begin
                cmd_in.kind = CMD_CLEAR;
            end
            REQ_READ: begin
                // out-of-range read answers zero without touching the store
                cmd_in.kind = (32'(i_req.cell_index) < CELL_COUNT) ? CMD_READ : CMD_NOP;
            end
            default: begin
                cmd_in.kind = CMD_NOP;
            end
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_cmd_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tcw_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Owns the cell store and cursor; runs puts, reads, clear and scroll sweeps.
module tcw_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire tcw_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    input  wire logic          i_res_free,
    output logic               o_res_we,
    output tcw_pkg::t_res      o_res,
    output logic               o_boot
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CLEAR  = 4'b0010,
        S_SCROLL = 4'b0100,
        S_READ   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic              r_boot, n_boot;
    logic [ADDR_W-1:0] r_wr, n_wr;
    logic [ADDR_W-1:0] r_cur, n_cur;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    logic [15:0]       r_mem [0:CELL_COUNT-1];
    logic [15:0]       r_rdata;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    assign o_boot = r_boot;

    always_comb begin
        n_state   = r_state;
        n_boot    = r_boot;
        n_wr      = r_wr;
        n_cur     = r_cur;
        n_col     = r_col;
        n_row     = r_row;
        mem_we    = 1'b0;
        mem_waddr = r_wr;
        mem_wdata = BLANK_CELL;
        mem_re    = 1'b0;
        mem_raddr = ROW_STEP;
        o_cmd_pop = 1'b0;
        o_res_we  = 1'b0;
        o_res.cursor_pos = 11'(r_cur);
        o_res.scrolled   = 1'b0;
        o_res.read_data  = 16'h0000;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_res_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_PUT, CMD_NEWLINE: begin
                            if (i_cmd.kind == CMD_PUT) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_cur;
                                mem_wdata = i_cmd.cell_word;
                            end
                            if ((i_cmd.kind == CMD_PUT && r_cur == LAST_CELL) ||
                                (i_cmd.kind == CMD_NEWLINE && r_row == LAST_ROW)) begin
                                // scroll: prefetch the first source cell
                                n_state = S_SCROLL;
                                n_wr    = '0;
                                mem_re  = 1'b1;
                                n_cur   = LAST_ROW_START;
                                n_row   = LAST_ROW;
                                n_col   = '0;
                            end else begin
                                if (i_cmd.kind == CMD_NEWLINE) begin
                                    n_cur = r_cur - ADDR_W'(r_col) + ROW_STEP;
                                    n_col = '0;
                                    n_row = r_row + 1'b1;
                                end else begin
                                    n_cur = r_cur + 1'b1;
                                    if (r_col == LAST_COL) begin
                                        n_col = '0;
                                        n_row = r_row + 1'b1;
                                    end else begin
                                        n_col = r_col + 1'b1;
                                    end
                                end
                                o_res_we         = 1'b1;
                                o_res.cursor_pos = 11'(n_cur);
                            end
                        end
                        CMD_CLEAR: begin
                            n_state = S_CLEAR;
                            n_wr    = '0;
                            n_cur   = '0;
                            n_col   = '0;
                            n_row   = '0;
                        end
                        CMD_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = i_cmd.idx;
                            n_state   = S_READ;
                        end
                        default: begin
                            o_res_we = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_res_we        = 1'b1;
                o_res.read_data = r_rdata;
                n_state         = S_IDLE;
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                n_wr   = r_wr + 1'b1;
                if (r_wr == LAST_CELL) begin
                    n_state = S_IDLE;
                    n_boot  = 1'b0;
                    o_res_we = !r_boot;
                end
            end
            S_SCROLL: begin
                mem_we    = 1'b1;
                mem_wdata = (r_wr < LAST_ROW_START) ? r_rdata : BLANK_CELL;
                mem_re    = (r_wr < COPY_READ_END);
                mem_raddr = r_wr + READ_AHEAD;
                n_wr      = r_wr + 1'b1;
                if (r_wr == LAST_CELL) begin
                    n_state        = S_IDLE;
                    o_res_we       = 1'b1;
                    o_res.scrolled = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_boot  <= 1'b1;
            r_wr    <= '0;
            r_cur   <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
            r_wr    <= n_wr;
            r_cur   <= n_cur;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    a_res_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_we && r_state == S_IDLE |-> i_res_free)
        else $error("result written while slot occupied");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < CELL_COUNT)
        else $error("cursor beyond store");

    a_cur_rowcol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) * SCREEN_WIDTH + 32'(r_col) == 32'(r_cur))
        else $error("cursor row/column out of step with linear cursor");

    a_boot_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boot |-> !o_res_we && !o_cmd_pop)
        else $error("activity during power-up clear");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCROLL |-> r_cur == LAST_ROW_START)
        else $error("cursor not parked on last row during scroll");

endmodule

`default_nettype wire

FILE: rtl/text_console_writer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// -------   -------------------   ----------------------------------------------
// request   push / full           i_req: req_type, char_code, color, cell_index
// result    empty / pop           o_res: cursor_pos, scrolled, read_data
//
// A put or newline completes in the engine's idle state; a read also passes
// through S_READ (registered store read port); the front queue adds a register.
// Scroll and clear each take the issuing cycle, then one store write per
// cycle; the single-write-port cell store sets both.
// Reset: a clearing pass blanks the store; full stays high throughout.
// A result waits in the output register while the next requests queue up;
// the engine stalls only when that register is still held.
module text_console_writer_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    input  wire tcw_pkg::t_req i_req,
    output logic               full,
    output logic               empty,
    input  wire logic          pop,
    output tcw_pkg::t_res      o_res
);
    import tcw_pkg::*;

    logic front_full;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic res_free;
    logic res_we;
    t_res res;
    logic boot;

    // output register: one waiting result beat
    logic r_res_v;
    t_res r_res;

    // no request taken during the power-up clearing pass
    assign full = front_full | boot;

    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push & ~full),
        .i_req       (i_req),
        .o_full      (front_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // slot is free when empty or being drained this cycle
    assign res_free = !r_res_v || pop;

    tcw_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_free  (res_free),
        .o_res_we    (res_we),
        .o_res       (res),
        .o_boot      (boot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (res_we) begin
            r_res_v <= 1'b1;
        end else if (pop) begin
            r_res_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            r_res <= res;
        end
    end

    assign empty = !r_res_v;
    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: verif/tcw_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the console writer, keeps its own copy of the
// screen and cursor, and checks each result beat against the oldest prediction.
module tcw_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_full,
    input  wire tcw_pkg::t_req i_req,
    input  wire logic          i_empty,
    input  wire logic          i_pop,
    input  wire tcw_pkg::t_res i_res,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tcw_pkg::*;

    logic [15:0]       screen_mem [CELL_COUNT];
    logic [ADDR_W-1:0] cursor;
    t_res              due_results [$];
    int                fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one request to the shadow screen, returns the result it owes.
    function automatic t_res console_step(input t_req rq);
        t_res outcome;
        int   next_pos;
        int   k;
        outcome = '0;
        case (rq.req_type)
            REQ_PUT: begin
                if (rq.char_code == NEWLINE_CODE) begin
                    next_pos = (int'(cursor) / SCREEN_WIDTH + 1) * SCREEN_WIDTH;
                end else begin
                    screen_mem[cursor] = {rq.color, rq.char_code};
                    next_pos = int'(cursor) + 1;
                end
                if (next_pos >= CELL_COUNT) begin
                    for (k = 0; k < CELL_COUNT - SCREEN_WIDTH; k++)
                        screen_mem[k] = screen_mem[k + SCREEN_WIDTH];
                    for (k = CELL_COUNT - SCREEN_WIDTH; k < CELL_COUNT; k++)
                        screen_mem[k] = BLANK_CELL;
                    next_pos = CELL_COUNT - SCREEN_WIDTH;
                    outcome.scrolled = 1'b1;
                end
                cursor = ADDR_W'(next_pos);
            end
            REQ_CLEAR: begin
                for (k = 0; k < CELL_COUNT; k++)
                    screen_mem[k] = BLANK_CELL;
                cursor = '0;
            end
            REQ_READ: begin
                if (rq.cell_index < CELL_COUNT)
                    outcome.read_data = screen_mem[rq.cell_index];
            end
            default: ;  // unused code: no effect
        endcase
        outcome.cursor_pos = cursor;
        return outcome;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        int   k;
        if (!i_rst_n) begin
            for (k = 0; k < CELL_COUNT; k++)
                screen_mem[k] = BLANK_CELL;
            cursor = '0;
            due_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (due_results.size() == 0) begin
                    $error("result beat with nothing expected: cursor_pos %0d scrolled %0d read_data %h",
                           i_res.cursor_pos, i_res.scrolled, i_res.read_data);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    if (i_res.cursor_pos !== want.cursor_pos) begin
                        $error("cursor_pos: expected %0d, got %0d",
                               want.cursor_pos, i_res.cursor_pos);
                        fails++;
                    end
                    if (i_res.scrolled !== want.scrolled) begin
                        $error("scrolled: expected %0d, got %0d", want.scrolled, i_res.scrolled);
                        fails++;
                    end
                    if (i_res.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, i_res.read_data);
                        fails++;
                    end
                end
            end
            if (i_push && !i_full)
                due_results.push_back(console_step(i_req));
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

// Top of the console writer bench. This module only makes traffic and gives
// the verdict; tcw_checker predicts every result beat and compares it.
//
// Traffic: a short directed run (reads at both ends of the store and past it,
// extreme characters and colors, the unused request code, a clear, then a
// column of newlines that ends in a scroll from the last row), followed by
// random bursts of text. Each burst picks its own newline density, so some
// bursts run long lines that wrap and scroll on the last row by plain
// characters, others are newline heavy. Reads, clears and unused codes are
// mixed in.
//
// Flow control goes through three phases: sender idles often and receiver
// more often, then the reverse, then neither idles. Between the first two the
// sender drains everything; the last phase starts with a long receiver hold
// so the front queue backs up and full holds the sender off.
module tb;
    import tcw_pkg::*;

    // request code the block has no use for; must leave all state alone
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RX_HOLD_CYCLES = 3000;  // longer than a scroll, so the queue fills
    localparam int TAIL_CYCLES    = 100;   // quiet time after the last result

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_req i_req   = '0;
    logic full;
    logic empty;
    t_res o_res;

    int fail_count;
    int pending;

    // idle percentages, owned by the sender process, read by the receiver
    int tx_idle = 0;
    int rx_idle = 0;
    bit hold_rx = 1'b0;

    text_console_writer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_req   (i_req),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    tcw_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_req        (i_req),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond a run where every item scrolls and every beat
    // waits out the longest stall.
    initial begin
        #50ms;
        $display("text_console_writer_unit verification failed");
        $finish;
    end

    // Offers one request beat and holds it until it is taken, then idles at
    // the sender's idle rate. Called at a rising edge; returns at one.
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] ch,
                             input logic [7:0] col, input logic [10:0] idx);
        t_req beat;
        beat.req_type   = kind;
        beat.char_code  = ch;
        beat.color      = col;
        beat.cell_index = idx;
        push  <= 1'b1;
        i_req <= beat;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        while (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Random text bursts. Unused-code beats are noise and don't count.
    task automatic random_items(input int count);
        int          done_n;
        int          burst;
        int          nl_pct;
        int          roll;
        logic [7:0]  ch;
        logic [10:0] idx;
        done_n = 0;
        while (done_n < count) begin
            // mostly short bursts; now and then a run of a row or more
            burst = ($urandom_range(9) == 0) ? $urandom_range(80, 120) : $urandom_range(1, 30);
            case ($urandom_range(2))
                0:       nl_pct = 0;
                1:       nl_pct = 10;
                default: nl_pct = 40;
            endcase
            repeat (burst) begin
                roll = $urandom_range(999);
                if (roll < 3) begin
                    // clear is rare so the cursor gets down to the last row
                    send_beat(REQ_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
                    done_n++;
                end else if (roll < 33) begin
                    send_beat(REQ_UNUSED, 8'($urandom), 8'($urandom), 11'($urandom));
                end else if (roll < 233) begin
                    // bias toward the last row, where writes land after a scroll
                    if ($urandom_range(3) == 0)
                        idx = 11'($urandom_range(LAST_ROW_START, CELL_COUNT - 1));
                    else
                        idx = 11'($urandom);  // includes indexes past the store
                    send_beat(REQ_READ, 8'($urandom), 8'($urandom), idx);
                    done_n++;
                end else begin
                    ch = ($urandom_range(99) < nl_pct) ? NEWLINE_CODE : 8'($urandom);
                    send_beat(REQ_PUT, ch, 8'($urandom), 11'($urandom));
                    done_n++;
                end
            end
        end
    endtask

    // Sender stops and waits until the checker has nothing left owed.
    task automatic drain;
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: pops at random, or sits out a long hold when asked.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                hold_rx = 1'b0;
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pop <= ($urandom_range(99) >= rx_idle);
                @(posedge i_clk);
            end
        end
    end

    // Sender and verdict
    initial begin
        tx_idle = 35;
        rx_idle = 58;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: the store starts blank; reads at both ends and past the end
        send_beat(REQ_READ, 8'h00, 8'h00, 11'd0);
        send_beat(REQ_READ, 8'hFF, 8'hFF, 11'(CELL_COUNT - 1));
        send_beat(REQ_READ, 8'h00, 8'h00, 11'(CELL_COUNT));
        send_beat(REQ_READ, 8'h00, 8'h00, 11'h7FF);
        // extreme characters and colors, then read them back
        send_beat(REQ_PUT, 8'h00, 8'h00, 11'h7FF);
        send_beat(REQ_PUT, 8'hFF, 8'hFF, 11'd0);
        send_beat(REQ_READ, 8'h00, 8'h00, 11'd0);
        send_beat(REQ_READ, 8'h00, 8'h00, 11'd1);
        // unused code with every field high: nothing moves
        send_beat(REQ_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
        send_beat(REQ_READ, 8'h00, 8'h00, 11'd2);
        send_beat(REQ_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
        send_beat(REQ_READ, 8'h00, 8'h00, 11'd1);
        // one newline per row; the last one is on the last row and scrolls
        repeat (SCREEN_HEIGHT) send_beat(REQ_PUT, NEWLINE_CODE, 8'hFF, 11'd0);
        send_beat(REQ_PUT, 8'h41, 8'h1E, 11'd0);
        send_beat(REQ_READ, 8'h00, 8'h00, LAST_ROW_START);

        random_items(200);

        // sender pause until every result is back, then swap idle rates
        drain();
        tx_idle = 58;
        rx_idle = 35;
        random_items(200);

        // no idling; receiver holds off long enough for full to rise
        tx_idle = 0;
        rx_idle = 0;
        hold_rx = 1'b1;
        random_items(100);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("text_console_writer_unit verification clean");
        else
            $display("text_console_writer_unit verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_engine.sv
rtl/text_console_writer_unit.sv
verif/tcw_checker.sv
verif/tb.sv
